@@ src/dual_servo_pwm_generator_macros.svh @@
// Assertion macros shared by the servo PWM generator RTL.
// Standalone header; taken in by the modules that carry checks.
`ifndef DUAL_SERVO_PWM_GENERATOR_MACROS_SVH
`define DUAL_SERVO_PWM_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
// expression must hold at every clock edge out of reset
`define DSP_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("dsp check failed");
// consequent must hold in the cycle after the antecedent
`define DSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsp check failed");
`else
`define DSP_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define DSP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/dsp_pkg.sv @@
// Shared types and constants of the dual servo PWM generator.
// No dependencies; imported by every module of the block.
package dsp_pkg;

  localparam int CNT_W     = 16;   // timer counter width
  localparam int ANG_W     = 16;
  localparam int PRESC_W   = 10;
  localparam int DIVR_W    = 11;
  localparam int Q_DEPTH   = 2;    // front to back queue
  localparam int OUT_W     = 24;   // result beat, padded to bytes
  localparam int PROD_W    = 2 * CNT_W;
  localparam int STEP_W    = $clog2(PROD_W);
  localparam int ADDR_W    = 5;

  localparam logic [DIVR_W-1:0] PRESC_MAX = 11'd1024;

  // configuration register indexes (byte address / 4)
  localparam logic [2:0] REG_PERIOD_TOP   = 3'd0;
  localparam logic [2:0] REG_PULSE_MIN    = 3'd1;
  localparam logic [2:0] REG_PULSE_MAX    = 3'd2;
  localparam logic [2:0] REG_FULL_SCALE   = 3'd3;
  localparam logic [2:0] REG_PRESCALE     = 3'd4;
  localparam logic [2:0] REG_CHAN_ENABLE  = 3'd5;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_SET  = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0]  period_top;
    logic [CNT_W-1:0]  pulse_min;
    logic [CNT_W-1:0]  pulse_max;
    logic [ANG_W-1:0]  full_scale;
    logic [DIVR_W-1:0] prescale;
    logic [1:0]        enable;
  } cfg_t;

  typedef struct packed {
    logic             is_set;
    logic             channel;
    logic [ANG_W-1:0] angle;
  } item_t;

  typedef struct packed {
    logic             start;
    logic             ack;
    logic [ANG_W-1:0] angle;
  } wu_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] width;
  } wu_rsp_t;

  typedef struct packed {
    logic             busy_b;
    logic             busy_a;
    logic [CNT_W-1:0] count_now;
    logic             wrapped;
    logic             pin_b;
    logic             pin_a;
  } result_t;

  typedef enum logic [1:0] {
    WU_IDLE,
    WU_MUL,
    WU_DIV,
    WU_DONE
  } wu_state_t;

  typedef enum logic {
    BK_RUN,
    BK_WAIT
  } bk_state_t;

endpackage

@@ src/dual_servo_pwm_generator.sv @@
// Top level of the dual servo PWM generator: configuration registers and wiring.
// Depends on dsp_pkg, dsp_front, dsp_width and dsp_back.
//
// Usage:
//   Input beats arrive on in_t*: in_tuser[0] is the opcode (0 tick, 1 set angle),
//   in_tuser[1] the target channel, in_tdata[15:0] the angle. Every beat yields
//   exactly one result beat on out_t*, in order.
//   Result beat out_tdata, lowest bit up: pin_a, pin_b, wrapped, count_now[15:0],
//   busy_a, busy_b, three zero pad bits.
//   A tick result is registered in the front queue, then in the result register.
//   Throughput: tick beats run at one per cycle while the receiver keeps up and no
//   set-angle beat is in the width unit. A set-angle beat with a non-zero full
//   scale goes through the width unit, a multiply and then a 32-step restoring
//   divide; meanwhile later beats queue in the two-entry front queue and then hold
//   in_tready low. A zero full scale takes the minimum width without the width unit.
//   When the receiver stalls, the result register holds its beat, the back end
//   halts, the queue fills and in_tready drops; no beat is lost.
//   Reset (rst_n low, synchronous) restores the register defaults, clears the
//   timer, prescaler, buffers and pending flags, sets both compares to 2000
//   and empties the queue and the result register.
//   Configuration: APB writes at byte address 4*index, taken on the access
//   cycle; pready is tied high. Write only while the block is idle.
module dual_servo_pwm_generator (
  input  logic                        clk,
  input  logic                        rst_n,
  // in_tdata: angle[15:0]
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [dsp_pkg::ANG_W-1:0]   in_tdata,
  // in_tuser: opcode, channel
  input  logic [1:0]                  in_tuser,
  // out_tdata: pin_a, pin_b, wrapped, count_now[15:0], busy_a, busy_b, pad
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [dsp_pkg::OUT_W-1:0]   out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [dsp_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import dsp_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;
  logic       q_valid, q_pop;
  item_t      q_item;
  wu_req_t    wu_req;
  wu_rsp_t    wu_rsp;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[4:2];

  // register file: hold the defaults out of reset, drop writes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_top <= 16'd39999;
      cfg_r.pulse_min  <= 16'd2000;
      cfg_r.pulse_max  <= 16'd4000;
      cfg_r.full_scale <= 16'd180;
      cfg_r.prescale   <= 11'd8;
      cfg_r.enable     <= 2'd0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PERIOD_TOP:  cfg_r.period_top <= cfg_pwdata[CNT_W-1:0];
        REG_PULSE_MIN:   cfg_r.pulse_min  <= cfg_pwdata[CNT_W-1:0];
        REG_PULSE_MAX:   cfg_r.pulse_max  <= cfg_pwdata[CNT_W-1:0];
        REG_FULL_SCALE:  cfg_r.full_scale <= cfg_pwdata[ANG_W-1:0];
        REG_PRESCALE:    cfg_r.prescale   <= cfg_pwdata[DIVR_W-1:0];
        REG_CHAN_ENABLE: cfg_r.enable     <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PERIOD_TOP:  cfg_prdata = 32'(cfg_r.period_top);
      REG_PULSE_MIN:   cfg_prdata = 32'(cfg_r.pulse_min);
      REG_PULSE_MAX:   cfg_prdata = 32'(cfg_r.pulse_max);
      REG_FULL_SCALE:  cfg_prdata = 32'(cfg_r.full_scale);
      REG_PRESCALE:    cfg_prdata = 32'(cfg_r.prescale);
      REG_CHAN_ENABLE: cfg_prdata = 32'(cfg_r.enable);
      default:         cfg_prdata = '0;
    endcase
  end

  // front: take and classify beats, queue them
  dsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // shared multiply and serial divide for set-angle beats
  dsp_width u_width (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .req   (wu_req),
    .rsp   (wu_rsp)
  );

  // back: timer, compares and the result register
  dsp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .wu_req     (wu_req),
    .wu_rsp     (wu_rsp),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );
endmodule

@@ src/dsp_front.sv @@
// Front end: accepts input beats, classifies them and queues them for the back end.
// Depends on dsp_pkg.
`include "dual_servo_pwm_generator_macros.svh"
module dsp_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [dsp_pkg::ANG_W-1:0]  in_tdata,
  input  logic [1:0]                 in_tuser,
  output logic                       q_valid,
  output dsp_pkg::item_t             q_item,
  input  logic                       q_pop
);
  import dsp_pkg::*;

  localparam int QP_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam logic [QP_W:0] FULL = (QP_W + 1)'(Q_DEPTH);

  item_t           q_r [Q_DEPTH];
  logic [QP_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QP_W:0]   cnt_r, cnt_nxt;
  logic            push;

  assign in_tready = (cnt_r != FULL);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_item    = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QP_W'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (q_pop) begin
      rp_nxt = (rp_r == QP_W'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // classify: opcode marks a set-angle beat
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r].is_set  <= (in_tuser[0] == OP_SET);
      q_r[wp_r].channel <= in_tuser[1];
      q_r[wp_r].angle   <= in_tdata;
    end
  end

  `DSP_ASSERT_ALWAYS(a_fr_no_overfill, clk, rst_n, cnt_r <= FULL)
  `DSP_ASSERT_ALWAYS(a_fr_pop_needs_item, clk, rst_n, !q_pop || q_valid)
endmodule

@@ src/dsp_width.sv @@
// Pulse width unit: one multiply, then a bit-serial restoring divide by full scale.
// Depends on dsp_pkg.
`include "dual_servo_pwm_generator_macros.svh"
module dsp_width (
  input  logic              clk,
  input  logic              rst_n,
  input  dsp_pkg::cfg_t     cfg,
  input  dsp_pkg::wu_req_t  req,
  output dsp_pkg::wu_rsp_t  rsp
);
  import dsp_pkg::*;

  wu_state_t          state_r, state_nxt;
  logic [ANG_W-1:0]   ang_r;
  logic [CNT_W-1:0]   mag_r;
  logic               neg_r;
  logic [PROD_W-1:0]  quo_r;
  logic [ANG_W-1:0]   rem_r;
  logic [STEP_W-1:0]  step_r;
  logic [ANG_W:0]     trial;
  logic               fits;
  logic               in_idle, in_mul, in_div;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      WU_IDLE: if (req.start) state_nxt = WU_MUL;
      WU_MUL:  state_nxt = WU_DIV;
      WU_DIV:  if (step_r == STEP_W'(PROD_W - 1)) state_nxt = WU_DONE;
      WU_DONE: if (req.ack) state_nxt = WU_IDLE;
      default: state_nxt = WU_IDLE;
    endcase
  end

  always_comb begin
    in_idle  = 1'b0;
    in_mul   = 1'b0;
    in_div   = 1'b0;
    rsp.done = 1'b0;
    unique case (state_r)
      WU_IDLE: in_idle  = 1'b1;
      WU_MUL:  in_mul   = 1'b1;
      WU_DIV:  in_div   = 1'b1;
      WU_DONE: rsp.done = 1'b1;
      default: in_idle  = 1'b1;
    endcase
    // quotient never exceeds the span magnitude, so its low half is exact
    rsp.width = neg_r ? cfg.pulse_min - quo_r[CNT_W-1:0]
                      : cfg.pulse_min + quo_r[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= WU_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign trial = {rem_r, quo_r[PROD_W-1]};
  assign fits  = (trial >= {1'b0, cfg.full_scale});

  always_ff @(posedge clk) begin
    if (in_idle && req.start) begin
      // saturate the angle and split the span into sign and magnitude
      ang_r <= (req.angle > cfg.full_scale) ? cfg.full_scale : req.angle;
      neg_r <= (cfg.pulse_max < cfg.pulse_min);
      mag_r <= (cfg.pulse_max < cfg.pulse_min) ? cfg.pulse_min - cfg.pulse_max
                                               : cfg.pulse_max - cfg.pulse_min;
    end
    if (in_mul) begin
      quo_r  <= PROD_W'(mag_r) * PROD_W'(ang_r);
      rem_r  <= '0;
      step_r <= '0;
    end
    if (in_div) begin
      rem_r  <= fits ? ANG_W'(trial - {1'b0, cfg.full_scale}) : trial[ANG_W-1:0];
      quo_r  <= {quo_r[PROD_W-2:0], fits};
      step_r <= step_r + 1'b1;
    end
  end

  `DSP_ASSERT_NEXT(a_wu_start_from_idle, clk, rst_n, req.start, $past(state_r) == WU_IDLE)
  `DSP_ASSERT_NEXT(a_wu_done_holds, clk, rst_n, rsp.done && !req.ack, rsp.done)
endmodule

@@ src/dsp_back.sv @@
// Back end: prescaler, timer, buffered compares and the registered result beat.
// Depends on dsp_pkg; drives the width unit through wu_req_t / wu_rsp_t.
`include "dual_servo_pwm_generator_macros.svh"
module dsp_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dsp_pkg::cfg_t             cfg,
  input  logic                      q_valid,
  input  dsp_pkg::item_t            q_item,
  output logic                      q_pop,
  output dsp_pkg::wu_req_t          wu_req,
  input  dsp_pkg::wu_rsp_t          wu_rsp,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [dsp_pkg::OUT_W-1:0] out_tdata
);
  import dsp_pkg::*;

  localparam logic [CNT_W-1:0] CMP_RESET = 16'd2000;

  bk_state_t          state_r, state_nxt;
  logic [PRESC_W-1:0] presc_r, presc_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   cmp_a_r, cmp_a_nxt, cmp_b_r, cmp_b_nxt;
  logic [CNT_W-1:0]   buf_a_r, buf_a_nxt, buf_b_r, buf_b_nxt;
  logic               pend_a_r, pend_a_nxt, pend_b_r, pend_b_nxt;
  logic               wait_ch_r;
  logic               out_valid_r;
  result_t            out_r, res;

  logic               slot_free, fs_zero, do_tick, do_set_now, do_set_late, emit;
  logic               set_ch, step, wrap;
  logic [CNT_W-1:0]   set_w;
  logic [DIVR_W-1:0]  div_eff;

  assign slot_free = !out_valid_r || out_tready;
  assign fs_zero   = (cfg.full_scale == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_RUN:  if (q_valid && slot_free && q_item.is_set && !fs_zero) state_nxt = BK_WAIT;
      BK_WAIT: if (wu_rsp.done && slot_free) state_nxt = BK_RUN;
      default: state_nxt = BK_RUN;
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    wu_req.ack   = 1'b0;
    unique case (state_r)
      BK_RUN:  q_pop      = q_valid && slot_free;
      BK_WAIT: wu_req.ack = wu_rsp.done && slot_free;
      default: q_pop      = 1'b0;
    endcase
    wu_req.start = q_pop && q_item.is_set && !fs_zero;
    wu_req.angle = q_item.angle;
  end

  assign do_tick     = q_pop && !q_item.is_set;
  assign do_set_now  = q_pop && q_item.is_set && fs_zero;
  assign do_set_late = wu_req.ack;
  assign emit        = do_tick || do_set_now || do_set_late;
  assign set_ch      = do_set_now ? q_item.channel : wait_ch_r;
  assign set_w       = do_set_now ? cfg.pulse_min : wu_rsp.width;

  always_comb begin
    if (cfg.prescale == '0) begin
      div_eff = DIVR_W'(1);
    end else if (cfg.prescale > PRESC_MAX) begin
      div_eff = PRESC_MAX;
    end else begin
      div_eff = cfg.prescale;
    end
  end

  assign step = ({1'b0, presc_r} + DIVR_W'(1)) >= div_eff;
  assign wrap = do_tick && step && (cnt_r >= cfg.period_top);

  always_comb begin
    presc_nxt  = presc_r;
    cnt_nxt    = cnt_r;
    cmp_a_nxt  = cmp_a_r;
    cmp_b_nxt  = cmp_b_r;
    buf_a_nxt  = buf_a_r;
    buf_b_nxt  = buf_b_r;
    pend_a_nxt = pend_a_r;
    pend_b_nxt = pend_b_r;
    if (do_tick) begin
      if (step) begin
        presc_nxt = '0;
        if (wrap) begin
          cnt_nxt = '0;
          if (pend_a_r) begin
            cmp_a_nxt  = buf_a_r;
            pend_a_nxt = 1'b0;
          end
          if (pend_b_r) begin
            cmp_b_nxt  = buf_b_r;
            pend_b_nxt = 1'b0;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end else begin
        presc_nxt = presc_r + 1'b1;
      end
    end else if (do_set_now || do_set_late) begin
      if (set_ch) begin
        buf_b_nxt  = set_w;
        pend_b_nxt = 1'b1;
      end else begin
        buf_a_nxt  = set_w;
        pend_a_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    res.pin_a     = cfg.enable[0] && (cnt_nxt <= cmp_a_nxt);
    res.pin_b     = cfg.enable[1] && (cnt_nxt <= cmp_b_nxt);
    res.wrapped   = wrap;
    res.count_now = cnt_nxt;
    res.busy_a    = pend_a_nxt;
    res.busy_b    = pend_b_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_RUN;
      presc_r     <= '0;
      cnt_r       <= '0;
      cmp_a_r     <= CMP_RESET;
      cmp_b_r     <= CMP_RESET;
      buf_a_r     <= '0;
      buf_b_r     <= '0;
      pend_a_r    <= 1'b0;
      pend_b_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      presc_r  <= presc_nxt;
      cnt_r    <= cnt_nxt;
      cmp_a_r  <= cmp_a_nxt;
      cmp_b_r  <= cmp_b_nxt;
      buf_a_r  <= buf_a_nxt;
      buf_b_r  <= buf_b_nxt;
      pend_a_r <= pend_a_nxt;
      pend_b_r <= pend_b_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wu_req.start) begin
      wait_ch_r <= q_item.channel;
    end
    if (emit) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_r);

  `DSP_ASSERT_ALWAYS(a_bk_no_pop_while_wait, clk, rst_n, !(state_r == BK_WAIT && q_pop))
  `DSP_ASSERT_ALWAYS(a_bk_emit_needs_slot, clk, rst_n, !emit || slot_free)
  `DSP_ASSERT_NEXT(a_bk_cmp_only_on_wrap, clk, rst_n, !wrap,
                   cmp_a_r == $past(cmp_a_r) && cmp_b_r == $past(cmp_b_r))
endmodule

@@ test/dual_servo_pwm_generator_tb.sv @@
// Self-checking testbench for the dual servo PWM generator: directed rows, then random phases.
// Depends on dsp_pkg and the dual_servo_pwm_generator RTL; predicts every result beat itself.
module dual_servo_pwm_generator_tb;
  import dsp_pkg::*;

  localparam int STALL_LIMIT = 3000;  // cycles without any handshake before giving up
  localparam int PHASES = 8;
  localparam int PHASE_BEATS = 185;
  localparam int TAIL_CYCLES = 10;
  // register slots past the end of the map; writes there must change nothing
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {
    ROW_TICK,
    ROW_SET,
    ROW_CFG
  } row_kind_t;

  // sel is the channel of a set-angle row or the register index of a config row;
  // val is the angle or the register value; res is only used where typed is set
  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  sel;
    logic [31:0] val;
    logic        typed;
    result_t     res;
  } row_t;

  // Directed part. Typed results come straight from reset values and obvious steps;
  // the rest goes through the predictor.
  localparam row_t PLAN [40] = '{
    // reset defaults: prescaler at 8, so the counter stays at zero, pins disabled
    '{ROW_TICK, 3'd0, 32'd0, 1'b1, '0},
    '{ROW_SET, 3'd0, 32'd0, 1'b1, '{busy_a: 1, default: 0}},
    // angle far above full scale saturates
    '{ROW_SET, 3'd1, 32'd65535, 1'b1, '{busy_a: 1, busy_b: 1, default: 0}},
    '{ROW_TICK, 3'd0, 32'd0, 1'b1, '{busy_a: 1, busy_b: 1, default: 0}},
    // short period, prescaler of zero acts as one, both pins on
    '{ROW_CFG, REG_PERIOD_TOP, 32'd2, 1'b0, '0},
    '{ROW_CFG, REG_PRESCALE, 32'd0, 1'b0, '0},
    '{ROW_CFG, REG_CHAN_ENABLE, 32'd3, 1'b0, '0},
    '{ROW_TICK, 3'd0, 32'd0, 1'b1,
      '{pin_a: 1, pin_b: 1, count_now: 1, busy_a: 1, busy_b: 1, default: 0}},
    '{ROW_TICK, 3'd0, 32'd0, 1'b1,
      '{pin_a: 1, pin_b: 1, count_now: 2, busy_a: 1, busy_b: 1, default: 0}},
    // wrap: both buffered widths load, busy flags drop
    '{ROW_TICK, 3'd0, 32'd0, 1'b1, '{pin_a: 1, pin_b: 1, wrapped: 1, default: 0}},
    // falling span: maximum below minimum, quotient truncates toward zero
    '{ROW_CFG, REG_PULSE_MIN, 32'd5, 1'b0, '0},
    '{ROW_CFG, REG_PULSE_MAX, 32'd1, 1'b0, '0},
    '{ROW_CFG, REG_FULL_SCALE, 32'd3, 1'b0, '0},
    '{ROW_SET, 3'd0, 32'd1, 1'b0, '0},
    // a second set before the wrap replaces the buffered width
    '{ROW_SET, 3'd0, 32'd2, 1'b0, '0},
    '{ROW_SET, 3'd1, 32'd100, 1'b0, '0},
    '{ROW_TICK, 3'd0, 32'd0, 1'b0, '0},
    '{ROW_TICK, 3'd0, 32'd0, 1'b0, '0},
    '{ROW_TICK, 3'd0, 32'd0, 1'b0, '0},
    '{ROW_TICK, 3'd0, 32'd0, 1'b0, '0},
    '{ROW_TICK, 3'd0, 32'd0, 1'b0, '0},
    // top drops to zero under a running count: wrap on every step
    '{ROW_CFG, REG_PERIOD_TOP, 32'd0, 1'b0, '0},
    '{ROW_TICK, 3'd0, 32'd0, 1'b0, '0},
    '{ROW_TICK, 3'd0, 32'd0, 1'b0, '0},
    // zero full scale gives the minimum width
    '{ROW_CFG, REG_FULL_SCALE, 32'd0, 1'b0, '0},
    '{ROW_SET, 3'd0, 32'd500, 1'b0, '0},
    // prescaler above its range saturates; spare slots ignore writes
    '{ROW_CFG, REG_PRESCALE, 32'd2047, 1'b0, '0},
    '{ROW_CFG, REG_SPARE_LO, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_CFG, REG_SPARE_HI, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_TICK, 3'd0, 32'd0, 1'b0, '0},
    // full-range extremes
    '{ROW_CFG, REG_PULSE_MIN, 32'd0, 1'b0, '0},
    '{ROW_CFG, REG_PULSE_MAX, 32'd65535, 1'b0, '0},
    '{ROW_CFG, REG_FULL_SCALE, 32'd65535, 1'b0, '0},
    '{ROW_CFG, REG_PERIOD_TOP, 32'd65535, 1'b0, '0},
    '{ROW_CFG, REG_PRESCALE, 32'd1024, 1'b0, '0},
    '{ROW_SET, 3'd0, 32'd65535, 1'b0, '0},
    '{ROW_SET, 3'd1, 32'd32768, 1'b0, '0},
    '{ROW_SET, 3'd1, 32'd0, 1'b0, '0},
    '{ROW_SET, 3'd0, 32'd1, 1'b0, '0},
    '{ROW_TICK, 3'd0, 32'd0, 1'b0, '0}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [ANG_W-1:0]    in_tdata = '0;
  logic [1:0]          in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]   cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;

  // typed expectation travels alongside the beat it belongs to
  logic                row_typed = 1'b0;
  result_t             row_res = '0;

  // shadow of the register file, reset values
  logic [15:0]         top_r = 16'd39999;
  logic [15:0]         pmin_r = 16'd2000;
  logic [15:0]         pmax_r = 16'd4000;
  logic [15:0]         fs_r = 16'd180;
  logic [10:0]         div_r = 11'd8;
  logic [1:0]          en_r = 2'd0;

  // shadow of the timer and both channels
  logic [9:0]          presc_r = '0;
  logic [15:0]         tmr_r = '0;
  logic [15:0]         cmp_a = 16'd2000;
  logic [15:0]         cmp_b = 16'd2000;
  logic [15:0]         buf_a = '0;
  logic [15:0]         buf_b = '0;
  logic                pend_a = 1'b0;
  logic                pend_b = 1'b0;

  result_t             pwm_status_q [$];
  int                  beats_sent = 0;
  int                  results_seen = 0;
  int                  mismatches = 0;
  int                  quiet_cycles = 0;
  int                  rx_hold = 0;
  bit                  tx_calm = 1'b0;
  bit                  rx_calm = 1'b0;

  dual_servo_pwm_generator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly back to back, now and then a short gap, rarely a long one.
  function automatic int unsigned beat_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (calm || r > 5) return 0;
    if (r == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Scale an angle to a compare value; the span is signed and the quotient
  // truncates toward zero, so a falling span rounds up toward the minimum.
  function automatic logic [15:0] servo_width(input logic [15:0] ang);
    longint span;
    longint quot;
    logic [15:0] a;
    if (fs_r == 16'd0) return pmin_r;
    a = (ang > fs_r) ? fs_r : ang;
    span = longint'(pmax_r) - longint'(pmin_r);
    quot = span * longint'(a) / longint'(fs_r);
    return 16'(longint'(pmin_r) + quot);
  endfunction

  // Apply one accepted beat to the shadow timer and return the status it yields.
  function automatic result_t advance_servo(input logic op, input logic ch,
                                            input logic [15:0] ang);
    result_t r;
    int unsigned steps;
    logic [15:0] w;
    logic wrp;
    wrp = 1'b0;
    if (op == OP_SET) begin
      // set-angle only buffers; the timer holds still
      w = servo_width(ang);
      if (ch == 1'b0) begin
        buf_a = w;
        pend_a = 1'b1;
      end else begin
        buf_b = w;
        pend_b = 1'b1;
      end
    end else begin
      steps = (div_r == '0) ? 1 : (div_r > PRESC_MAX) ? int'(PRESC_MAX) : int'(div_r);
      if (int'(presc_r) + 1 >= steps) begin
        presc_r = '0;
        // at or past top the next step wraps, which also covers a lowered top
        if (tmr_r >= top_r) begin
          tmr_r = '0;
          wrp = 1'b1;
          if (pend_a) begin
            cmp_a = buf_a;
            pend_a = 1'b0;
          end
          if (pend_b) begin
            cmp_b = buf_b;
            pend_b = 1'b0;
          end
        end else begin
          tmr_r = tmr_r + 16'd1;
        end
      end else begin
        presc_r = presc_r + 10'd1;
      end
    end
    r.pin_a = en_r[0] && (tmr_r <= cmp_a);
    r.pin_b = en_r[1] && (tmr_r <= cmp_b);
    r.wrapped = wrp;
    r.count_now = tmr_r;
    r.busy_a = pend_a;
    r.busy_b = pend_b;
    return r;
  endfunction

  // Offer one beat after a random gap and hold it until the block takes it.
  task automatic send_beat(input logic op, input logic ch, input logic [15:0] ang,
                           input logic typed, input result_t res);
    int unsigned gap;
    gap = beat_gap(tx_calm);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= {ch, op};
    in_tdata <= ang;
    row_typed <= typed;
    row_res <= res;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  // Drop valid and hold until every outstanding result has come back.
  task automatic wait_for_results();
    if (in_tvalid) in_tvalid <= 1'b0;
    while (results_seen < beats_sent) @(posedge clk);
  endtask

  // Setup then access; psel stays high so writes can run back to back.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_PERIOD_TOP:  top_r = val[15:0];
      REG_PULSE_MIN:   pmin_r = val[15:0];
      REG_PULSE_MAX:   pmax_r = val[15:0];
      REG_FULL_SCALE:  fs_r = val[15:0];
      REG_PRESCALE:    div_r = val[10:0];
      REG_CHAN_ENABLE: en_r = val[1:0];
      default: ;
    endcase
  endtask

  // Receiver: stall for random stretches unless the current phase runs calm.
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      out_tready <= 1'b1;
      rx_hold = beat_gap(rx_calm);
    end
  end

  // Predict on every accepted input beat, check on every accepted result beat.
  always @(posedge clk) begin : scoreboard
    result_t pred;
    result_t want;
    result_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pred = advance_servo(in_tuser[0], in_tuser[1], in_tdata);
        pwm_status_q.push_back(row_typed ? row_res : pred);
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        got = result_t'(out_tdata[$bits(result_t)-1:0]);
        if (pwm_status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: no beat outstanding, got %h", results_seen, out_tdata);
        end else begin
          want = pwm_status_q.pop_front();
          // pad bits above the status fields must read zero as well
          if (got !== want || out_tdata[OUT_W-1:$bits(result_t)] !== '0) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("result %0d: want pin_a=%b pin_b=%b wrapped=%b count_now=%0d ",
                     results_seen, want.pin_a, want.pin_b, want.wrapped, want.count_now);
              $write("busy_a=%b busy_b=%b, got pin_a=%b pin_b=%b wrapped=%b ",
                     want.busy_a, want.busy_b, got.pin_a, got.pin_b, got.wrapped);
              $display("count_now=%0d busy_a=%b busy_b=%b pad=%b",
                       got.count_now, got.busy_a, got.busy_b,
                       out_tdata[OUT_W-1:$bits(result_t)]);
            end
          end
        end
      end
    end
  end

  // Watchdog: count cycles in which nothing moves on any port.
  always @(posedge clk) begin
    if (rst_n && !((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                   (cfg_psel && cfg_penable)))
      quiet_cycles = quiet_cycles + 1;
    else
      quiet_cycles = 0;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL dual_servo_pwm_generator");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    int p;
    int k;
    logic op;
    logic [15:0] ang;
    logic [15:0] top_v;
    logic [15:0] lo_v;
    logic [15:0] hi_v;
    logic [15:0] fs_v;
    logic [10:0] div_v;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // walk the directed rows; config rows wait for the block to go idle first
    for (i = 0; i < $size(PLAN); i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        wait_for_results();
        write_reg(PLAN[i].sel, PLAN[i].val);
      end else begin
        send_beat((PLAN[i].kind == ROW_SET) ? OP_SET : OP_TICK, PLAN[i].sel[0],
                  PLAN[i].val[15:0], PLAN[i].typed, PLAN[i].res);
      end
    end

    // random phases: short periods and small prescalers so wraps come often,
    // with the odd extreme setting thrown in
    for (p = 0; p < PHASES; p++) begin
      wait_for_results();
      case ($urandom_range(0, 9))
        0: top_v = 16'd0;
        1: top_v = 16'hFFFF;
        default: top_v = 16'($urandom_range(1, 40));
      endcase
      if ($urandom_range(0, 4) == 0) begin
        lo_v = 16'($urandom());
        hi_v = 16'($urandom());
      end else begin
        lo_v = 16'($urandom_range(0, 12));
        hi_v = 16'($urandom_range(0, int'(top_v) + 4));
      end
      case ($urandom_range(0, 9))
        0: fs_v = 16'd0;
        1: fs_v = 16'hFFFF;
        default: fs_v = 16'($urandom_range(1, 200));
      endcase
      case ($urandom_range(0, 9))
        0: div_v = 11'd0;
        1: div_v = PRESC_MAX;
        2: div_v = 11'h7FF;
        default: div_v = 11'($urandom_range(1, 3));
      endcase
      // junk above each register's width must be dropped
      write_reg(REG_PERIOD_TOP, {16'($urandom()), top_v});
      write_reg(REG_PULSE_MIN, {16'($urandom()), lo_v});
      write_reg(REG_PULSE_MAX, {16'($urandom()), hi_v});
      write_reg(REG_FULL_SCALE, {16'($urandom()), fs_v});
      write_reg(REG_PRESCALE, {21'($urandom()), div_v});
      write_reg(REG_CHAN_ENABLE, {30'($urandom()), 2'($urandom())});
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);

      for (k = 0; k < PHASE_BEATS; k++) begin
        // halfway through, starve the block until it has caught up
        if (k == PHASE_BEATS / 2) begin
          wait_for_results();
          tx_calm = ($urandom_range(0, 3) == 0);
          rx_calm = ($urandom_range(0, 3) == 0);
        end
        op = ($urandom_range(0, 7) == 0) ? OP_SET : OP_TICK;
        if ($urandom_range(0, 3) == 0)
          ang = 16'($urandom());
        else
          ang = 16'($urandom_range(0, int'(fs_r) + 2));
        send_beat(op, 1'($urandom()), ang, 1'b0, '0);
      end
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pwm_status_q.size() == 0)
      $display("PASS dual_servo_pwm_generator");
    else
      $display("FAIL dual_servo_pwm_generator");
    $finish;
  end

endmodule
